### hdl/rbws_pkg.sv
// ----------------------------------------------------------------------------
// rbws_pkg
// Shared types and codes for the read-batching request scheduler.
// ----------------------------------------------------------------------------
package rbws_pkg;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_DISPATCH = 2'd1,
    OP_REMOVE   = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_DISPATCHED = 3'd0,
    ST_QUEUED     = 3'd1,
    ST_FULL       = 3'd2,
    ST_REMOVED    = 3'd3,
    ST_NOT_FOUND  = 3'd4,
    ST_EMPTY      = 3'd5
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_PASS
  } state_t;

  // what a rotation pass drops as words leave the head cell
  typedef enum logic [1:0] {
    M_REM,
    M_WR,
    M_RD,
    M_HEAD
  } mode_t;

  typedef enum logic {
    REG_BATCH  = 1'b0,
    REG_STARVE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  localparam logic [3:0] BATCH_MAX    = 4'd8;
  localparam logic [3:0] BATCH_RESET  = 4'd4;
  localparam logic [7:0] STARVE_RESET = 8'd16;
  localparam logic [8:0] COUNT_MAX    = 9'd511;

endpackage

### hdl/rbws_cell.sv
// ----------------------------------------------------------------------------
// rbws_cell
// One queue slot: takes its upper neighbour on shift, or a broadcast entry on
// load.
// ----------------------------------------------------------------------------
module rbws_cell #(
  parameter int TAG_BITS = 8
) (
  input  logic                 clk,
  input  rbws_pkg::cell_ctl_t  ctl,
  input  logic [TAG_BITS-1:0]  nb_tag,
  input  logic                 nb_wr,
  input  logic [TAG_BITS-1:0]  ld_tag,
  input  logic                 ld_wr,
  output logic [TAG_BITS-1:0]  tag,
  output logic                 wr
);
  import rbws_pkg::*;

  logic [TAG_BITS-1:0] tag_r;
  logic                wr_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      tag_r <= ld_tag;
      wr_r  <= ld_wr;
    end else if (ctl.shift) begin
      tag_r <= nb_tag;
      wr_r  <= nb_wr;
    end
  end

  assign tag = tag_r;
  assign wr  = wr_r;

endmodule

### hdl/read_batch_write_starve_scheduler.sv
// ----------------------------------------------------------------------------
// read_batch_write_starve_scheduler
// Arrival-ordered request queue held in a chain of slot cells.
// ----------------------------------------------------------------------------
// Add and empty dispatch: handled on acceptance, result in the output register.
// Remove and dispatch rotate the queue through the cell chain, one slot per
// cycle while the output is not stalled; a starved dispatch with no write, or a
// dispatch finding no read, runs a further pass. Reads of a batch stream out.
// Synchronous active-low reset empties the queue, clears the read counter and
// restores the limits to 4 and 16; slot contents are not cleared.
module read_batch_write_starve_scheduler #(
  parameter int QUEUE_DEPTH = 32,
  parameter int TAG_BITS    = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // operation[1:0], request_tag[9:2], is_write[10]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // out_tag[7:0], out_is_write[8], status[11:9]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import rbws_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int EW = (TAG_BITS > 8) ? TAG_BITS : 8;

  // chain
  logic [TAG_BITS-1:0] c_tag [QUEUE_DEPTH];
  logic                c_wr  [QUEUE_DEPTH];
  cell_ctl_t           c_ctl [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] ld_tag;
  logic                ld_wr;
  logic                shift;
  logic                load;
  logic [IW-1:0]       load_idx;

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic [TAG_BITS-1:0] nt;
      logic                nw;
      if (g == QUEUE_DEPTH - 1) begin : g_top
        assign nt = '0;
        assign nw = 1'b0;
      end else begin : g_mid
        assign nt = c_tag[g+1];
        assign nw = c_wr[g+1];
      end
      assign c_ctl[g].shift = shift;
      assign c_ctl[g].load  = load && (load_idx == IW'(g));
      rbws_cell #(.TAG_BITS(TAG_BITS)) u_cell (
        .clk(clk), .ctl(c_ctl[g]), .nb_tag(nt), .nb_wr(nw),
        .ld_tag(ld_tag), .ld_wr(ld_wr), .tag(c_tag[g]), .wr(c_wr[g])
      );
    end
  endgenerate

  // input fields
  op_t                 in_op;
  logic [EW-1:0]       in_ext;
  logic [TAG_BITS-1:0] in_tag;
  logic                in_wr;
  assign in_op  = op_t'(in_tdata[1:0]);
  assign in_ext = EW'(in_tdata[9:2]);
  assign in_tag = in_ext[TAG_BITS-1:0];
  assign in_wr  = in_tdata[10];

  // registers
  state_t              state_r, state_nxt;
  mode_t               mode_r, mode_nxt;
  logic [CW-1:0]       occ_r, occ_nxt;
  logic [CW-1:0]       k_r, k_nxt;
  logic [CW-1:0]       d_r, d_nxt;
  logic [8:0]          cnt_r, cnt_nxt;
  logic [3:0]          batch_r, batch_nxt;
  logic [7:0]          starve_r, starve_nxt;
  logic [3:0]          nsent_r, nsent_nxt;
  logic                found_r, found_nxt;
  logic [TAG_BITS-1:0] key_r, key_nxt;
  logic [TAG_BITS-1:0] rec_tag_r, rec_tag_nxt;
  logic                rec_wr_r, rec_wr_nxt;
  logic                pend_r, pend_nxt;
  logic [TAG_BITS-1:0] pend_tag_r, pend_tag_nxt;
  logic                ov_r, ov_nxt;
  logic [TAG_BITS-1:0] o_tag_r, o_tag_nxt;
  logic                o_wr_r, o_wr_nxt;
  status_t             o_st_r, o_st_nxt;
  logic                o_last_r, o_last_nxt;

  logic                adv;
  logic [3:0]          limit;
  logic [CW-1:0]       pos;
  logic                drop;
  logic                emit;
  logic [TAG_BITS-1:0] e_tag;
  logic                e_wr;
  status_t             e_st;
  logic                e_last;

  assign adv   = !ov_r || out_tready;
  assign limit = (batch_r == 4'd0) ? 4'd1 : ((batch_r > BATCH_MAX) ? BATCH_MAX : batch_r);
  assign pos   = occ_r - CW'(1) - d_r;
  assign in_tready = (state_r == S_IDLE) && adv;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt = state_r; mode_nxt = mode_r; occ_nxt = occ_r; k_nxt = k_r; d_nxt = d_r;
    cnt_nxt = cnt_r; batch_nxt = batch_r; starve_nxt = starve_r; nsent_nxt = nsent_r;
    found_nxt = found_r; key_nxt = key_r; rec_tag_nxt = rec_tag_r; rec_wr_nxt = rec_wr_r;
    pend_nxt = pend_r; pend_tag_nxt = pend_tag_r;
    emit = 1'b0; e_tag = '0; e_wr = 1'b0; e_st = ST_DISPATCHED; e_last = 1'b1;
    shift = 1'b0; load = 1'b0; load_idx = pos[IW-1:0]; ld_tag = c_tag[0]; ld_wr = c_wr[0];
    drop = 1'b0;

    if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BATCH:  batch_nxt  = cfg_data[3:0];
        REG_STARVE: starve_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && adv) begin
          k_nxt = '0; d_nxt = '0; found_nxt = 1'b0; pend_nxt = 1'b0; nsent_nxt = '0;
          key_nxt = in_tag;
          unique case (in_op)
            OP_ADD: begin
              emit = 1'b1; e_tag = in_tag; e_wr = in_wr;
              if (occ_r >= CW'(QUEUE_DEPTH)) begin
                e_st = ST_FULL;
              end else begin
                e_st = ST_QUEUED; load = 1'b1; load_idx = occ_r[IW-1:0];
                ld_tag = in_tag; ld_wr = in_wr; occ_nxt = occ_r + CW'(1);
              end
            end
            OP_DISPATCH: begin
              if (occ_r == '0) begin
                emit = 1'b1; e_st = ST_EMPTY;
              end else begin
                state_nxt = S_PASS;
                if (cnt_r >= {1'b0, starve_r}) begin
                  cnt_nxt = '0; mode_nxt = M_WR;
                end else begin
                  mode_nxt = M_RD;
                end
              end
            end
            OP_REMOVE: begin
              state_nxt = S_PASS; mode_nxt = M_REM;
            end
            default: ;
          endcase
        end
      end
      S_PASS: begin
        if (adv) begin
          if (k_r == occ_r) begin
            occ_nxt = occ_r - d_r; k_nxt = '0; d_nxt = '0;
            unique case (mode_r)
              M_REM: begin
                emit = 1'b1; state_nxt = S_IDLE;
                e_tag = key_r;
                e_wr = found_r ? rec_wr_r : 1'b0;
                e_st = found_r ? ST_REMOVED : ST_NOT_FOUND;
              end
              M_WR: begin
                if (found_r) begin
                  emit = 1'b1; state_nxt = S_IDLE; e_tag = rec_tag_r; e_wr = 1'b1;
                end else begin
                  mode_nxt = M_RD;
                end
              end
              M_RD: begin
                if (pend_r) begin
                  emit = 1'b1; state_nxt = S_IDLE; e_tag = pend_tag_r;
                end else begin
                  mode_nxt = M_HEAD;
                end
              end
              M_HEAD: begin
                emit = 1'b1; state_nxt = S_IDLE; e_tag = rec_tag_r; e_wr = rec_wr_r;
                cnt_nxt = '0;
              end
              default: ;
            endcase
          end else begin
            unique case (mode_r)
              M_REM:  drop = !found_r && (c_tag[0] == key_r);
              M_WR:   drop = !found_r && c_wr[0];
              M_RD:   drop = !c_wr[0] && (nsent_r < limit);
              M_HEAD: drop = (k_r == '0);
              default: drop = 1'b0;
            endcase
            shift = 1'b1;
            load  = !drop;
            k_nxt = k_r + CW'(1);
            if (drop) begin
              d_nxt = d_r + CW'(1);
              found_nxt = 1'b1; rec_tag_nxt = c_tag[0]; rec_wr_nxt = c_wr[0];
              if (mode_r == M_RD) begin
                // hold each read back one word so the final one can carry last
                nsent_nxt = nsent_r + 4'd1;
                if (cnt_r < COUNT_MAX) cnt_nxt = cnt_r + 9'd1;
                if (pend_r) begin
                  emit = 1'b1; e_tag = pend_tag_r; e_last = 1'b0;
                end
                pend_nxt = 1'b1; pend_tag_nxt = c_tag[0];
              end
            end
          end
        end
      end
      default: ;
    endcase

    ov_nxt = adv ? emit : ov_r;
    o_tag_nxt = o_tag_r; o_wr_nxt = o_wr_r; o_st_nxt = o_st_r; o_last_nxt = o_last_r;
    if (adv && emit) begin
      o_tag_nxt = e_tag; o_wr_nxt = e_wr; o_st_nxt = e_st; o_last_nxt = e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mode_r   <= M_RD;
      occ_r    <= '0;
      k_r      <= '0;
      d_r      <= '0;
      cnt_r    <= '0;
      batch_r  <= BATCH_RESET;
      starve_r <= STARVE_RESET;
      nsent_r  <= '0;
      found_r  <= 1'b0;
      pend_r   <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mode_r   <= mode_nxt;
      occ_r    <= occ_nxt;
      k_r      <= k_nxt;
      d_r      <= d_nxt;
      cnt_r    <= cnt_nxt;
      batch_r  <= batch_nxt;
      starve_r <= starve_nxt;
      nsent_r  <= nsent_nxt;
      found_r  <= found_nxt;
      pend_r   <= pend_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    rec_tag_r  <= rec_tag_nxt;
    rec_wr_r   <= rec_wr_nxt;
    pend_tag_r <= pend_tag_nxt;
    o_tag_r    <= o_tag_nxt;
    o_wr_r     <= o_wr_nxt;
    o_st_r     <= o_st_nxt;
    o_last_r   <= o_last_nxt;
  end

  logic [EW-1:0] o_ext;
  assign o_ext      = EW'(o_tag_r);
  assign out_tvalid = ov_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {4'd0, o_st_r, o_wr_r, o_ext[7:0]};

endmodule

### hdl/rbws_checker.sv
// ----------------------------------------------------------------------------
// rbws_checker
// Port-level checks on the scheduler's result stream.
// ----------------------------------------------------------------------------
module rbws_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);
  import rbws_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result word changed");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[11:9] != 3'd6 && out_tdata[11:9] != 3'd7)
    else $error("undefined status code");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11:9] != ST_DISPATCHED |-> out_tlast)
    else $error("non-dispatch result without last");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11:9] == ST_EMPTY |-> out_tdata[8:0] == 9'd0)
    else $error("empty result carries a request");

endmodule

bind read_batch_write_starve_scheduler rbws_checker u_rbws_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tlast(out_tlast)
);
